[hw/rtl/z80pd_pkg.sv]
// Shared types, codes and opcode tables for the Z80 instruction predecoder.
`default_nettype none
package z80pd_pkg;

  localparam logic [7:0] OP_PFX_IX = 8'hDD;
  localparam logic [7:0] OP_PFX_IY = 8'hFD;
  localparam logic [7:0] OP_PFX_CB = 8'hCB;
  localparam logic [7:0] OP_PFX_ED = 8'hED;
  localparam logic [7:0] OP_HALT   = 8'h76;
  localparam logic [7:0] OP_JR     = 8'h18;
  localparam logic [7:0] OP_DJNZ   = 8'h10;
  localparam logic [7:0] OP_JP     = 8'hC3;
  localparam logic [7:0] OP_CALL   = 8'hCD;
  localparam logic [7:0] OP_RET    = 8'hC9;
  localparam logic [7:0] OP_JP_HL  = 8'hE9;
  localparam logic [7:0] OP_RETI   = 8'h4D;
  localparam logic [7:0] MASK_C7   = 8'hC7;
  localparam logic [7:0] MASK_E7   = 8'hE7;
  localparam logic [7:0] MASK_RST  = 8'h38;
  localparam logic [7:0] ED_IMM16  = 8'h43;

  localparam logic [2:0] GRP_NONE = 3'd0;
  localparam logic [2:0] GRP_CB   = 3'd1;
  localparam logic [2:0] GRP_ED   = 3'd2;
  localparam logic [2:0] GRP_DD   = 3'd3;
  localparam logic [2:0] GRP_FD   = 3'd4;
  localparam logic [2:0] GRP_DDCB = 3'd5;
  localparam logic [2:0] GRP_FDCB = 3'd6;

  localparam logic [2:0] FLOW_NONE  = 3'd0;
  localparam logic [2:0] FLOW_JP    = 3'd1;
  localparam logic [2:0] FLOW_JPCC  = 3'd2;
  localparam logic [2:0] FLOW_CALL  = 3'd3;
  localparam logic [2:0] FLOW_CALLC = 3'd4;
  localparam logic [2:0] FLOW_RET   = 3'd5;
  localparam logic [2:0] FLOW_RETCC = 3'd6;

  localparam logic [1:0] IMM_NONE = 2'd0;
  localparam logic [1:0] IMM_8    = 2'd1;
  localparam logic [1:0] IMM_16   = 2'd2;

  typedef struct packed {
    logic [2:0]  insn_length;
    logic        illegal;
    logic [2:0]  prefix_group;
    logic [7:0]  opcode_byte;
    logic [15:0] immediate;
    logic [1:0]  immediate_size;
    logic [7:0]  displacement;
    logic        uses_displacement;
    logic        is_halt;
    logic [2:0]  flow_class;
    logic        target_valid;
    logic [15:0] branch_target;
  } pd_result_t;

  // Opcode plus own operand bytes for unprefixed opcodes.
  function automatic logic [1:0] op_size(input logic [7:0] op);
    logic [1:0] sz;
    sz = 2'd1;
    if (op[7:6] == 2'b00) begin
      if (op[2:0] == 3'd6) sz = 2'd2;
      else if (op[3:0] == 4'h1) sz = 2'd3;
      else if (op[2:0] == 3'd0 && op[5:4] != 2'b00) sz = 2'd2;
      else if ((op & MASK_E7) == 8'h22) sz = 2'd3;
    end else if (op[7:6] == 2'b11) begin
      if (op[2:0] == 3'd2 || op[2:0] == 3'd4) sz = 2'd3;
      else if (op[2:0] == 3'd6) sz = 2'd2;
      else if (op == OP_JP || op == OP_CALL) sz = 2'd3;
      else if (op == 8'hD3 || op == 8'hDB) sz = 2'd2;
    end
    return sz;
  endfunction

  function automatic logic hl_operand(input logic [7:0] op);
    logic r;
    r = 1'b0;
    if (op == 8'h34 || op == 8'h35 || op == 8'h36) r = 1'b1;
    else if (op == OP_HALT) r = 1'b0;
    else if ((op & MASK_C7) == 8'h46) r = 1'b1;
    else if (op[7:3] == 5'b01110) r = 1'b1;
    else if ((op & MASK_C7) == 8'h86) r = 1'b1;
    return r;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/z80_instruction_predecoder.sv]
// Top level of the Z80 instruction predecoder: input register, decode, result register.
// One window is taken per clock (busy stays low); its decoded instruction passes the input
// register and the result register and is then on the result ports, marked by a one-cycle
// done strobe. The path between the input and result registers is the prefix scan, the
// opcode length and operand selection, and one 16-bit add for relative targets. Results
// cannot be held off.
`default_nettype none
module z80_instruction_predecoder #(
  parameter int WINDOW_BYTES = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [8*WINDOW_BYTES-1:0] byte_window,
  input  wire logic [3:0]                bytes_available,
  input  wire logic [15:0]               instr_address,
  output logic                           done,
  output logic [2:0]                     insn_length,
  output logic                           illegal,
  output logic [2:0]                     prefix_group,
  output logic [7:0]                     opcode_byte,
  output logic [15:0]                    immediate,
  output logic [1:0]                     immediate_size,
  output logic signed [7:0]              displacement,
  output logic                           uses_displacement,
  output logic                           is_halt,
  output logic [2:0]                     flow_class,
  output logic                           target_valid,
  output logic [15:0]                    branch_target
);
  import z80pd_pkg::*;

  localparam logic [3:0] WIN_CNT = 4'(WINDOW_BYTES);

  logic                      in_valid;
  logic [8*WINDOW_BYTES-1:0] in_win;
  logic [3:0]                in_avail;
  logic [15:0]               in_addr;
  pd_result_t                dec;
  pd_result_t                res;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      in_valid <= start && !busy;
      done     <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_win   <= byte_window;
      in_avail <= (bytes_available > WIN_CNT) ? WIN_CNT : bytes_available;
      in_addr  <= instr_address;
    end
    if (in_valid) begin
      res <= dec;
    end
  end

  z80pd_decode #(
    .WINDOW_BYTES(WINDOW_BYTES)
  ) u_decode (
    .window (in_win),
    .avail  (in_avail),
    .addr   (in_addr),
    .res    (dec)
  );

  assign insn_length       = res.insn_length;
  assign illegal           = res.illegal;
  assign prefix_group      = res.prefix_group;
  assign opcode_byte       = res.opcode_byte;
  assign immediate         = res.immediate;
  assign immediate_size    = res.immediate_size;
  assign displacement      = res.displacement;
  assign uses_displacement = res.uses_displacement;
  assign is_halt           = res.is_halt;
  assign flow_class        = res.flow_class;
  assign target_valid      = res.target_valid;
  assign branch_target     = res.branch_target;

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("transfer did not produce a result strobe");

  a_illegal_clean: assert property (@(posedge clk) disable iff (rst)
    (done && illegal) |-> (prefix_group == GRP_NONE && insn_length != 3'd0 &&
                           flow_class == FLOW_NONE && !target_valid))
    else $error("prefix-only window carries decode fields");

  a_target_flow: assert property (@(posedge clk) disable iff (rst)
    (done && target_valid) |-> (flow_class == FLOW_JP || flow_class == FLOW_JPCC ||
                                flow_class == FLOW_CALL || flow_class == FLOW_CALLC))
    else $error("branch target on non-branch");

  a_disp_group: assert property (@(posedge clk) disable iff (rst)
    (done && uses_displacement) |-> (prefix_group == GRP_DD || prefix_group == GRP_FD ||
                                     prefix_group == GRP_DDCB ||
                                     prefix_group == GRP_FDCB))
    else $error("displacement without index prefix");

endmodule
`default_nettype wire

[hw/rtl/z80pd_decode.sv]
// Combinational decode of one registered instruction window.
`default_nettype none
module z80pd_decode #(
  parameter int WINDOW_BYTES = 8
) (
  input  wire logic [8*WINDOW_BYTES-1:0] window,
  input  wire logic [3:0]                avail,
  input  wire logic [15:0]               addr,
  output z80pd_pkg::pd_result_t          res
);
  import z80pd_pkg::*;

  logic [63:0] wpad;
  logic [7:0]  bx [16];
  logic        run;
  logic [3:0]  np;
  logic [2:0]  pfx;
  logic [7:0]  b;
  logic [7:0]  opc;
  logic [3:0]  len;
  logic [1:0]  sz;
  logic        dd;
  logic [3:0]  at;
  logic [15:0] e;

  assign wpad = 64'(window);

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      if (4'(k) < avail) bx[k] = wpad[k*8 +: 8];
      else bx[k] = 8'h00;
    end
    for (int k = 8; k < 16; k++) begin
      bx[k] = 8'h00;
    end
  end

  always_comb begin
    run = 1'b1;
    np  = 4'd0;
    pfx = GRP_NONE;
    for (int k = 0; k < 8; k++) begin
      if (run && (bx[k] == OP_PFX_IX || bx[k] == OP_PFX_IY)) begin
        pfx = (bx[k] == OP_PFX_IX) ? GRP_DD : GRP_FD;
        np  = 4'(k + 1);
      end else begin
        run = 1'b0;
      end
    end
  end

  always_comb begin
    res = '0;
    b   = bx[np];
    opc = 8'h00;
    len = 4'd0;
    sz  = op_size(b);
    dd  = (pfx != GRP_NONE) && hl_operand(b);
    at  = np + 4'd1 + {3'd0, dd};
    e   = 16'h0000;
    if (avail == 4'd0) begin
      len = 4'd0;
    end else if (np >= avail) begin
      res.illegal = 1'b1;
      len = avail;
    end else begin
      if (b == OP_PFX_CB) begin
        if (pfx != GRP_NONE) begin
          res.prefix_group      = (pfx == GRP_DD) ? GRP_DDCB : GRP_FDCB;
          res.displacement      = bx[np + 4'd1];
          res.uses_displacement = 1'b1;
          res.opcode_byte       = bx[np + 4'd2];
          len = np + 4'd3;
        end else begin
          res.prefix_group = GRP_CB;
          res.opcode_byte  = bx[np + 4'd1];
          len = np + 4'd2;
        end
      end else if (b == OP_PFX_ED) begin
        opc = bx[np + 4'd1];
        res.prefix_group = GRP_ED;
        res.opcode_byte  = opc;
        if ((opc & MASK_C7) == ED_IMM16) begin
          res.immediate      = {bx[np + 4'd3], bx[np + 4'd2]};
          res.immediate_size = IMM_16;
          len = np + 4'd4;
        end else begin
          len = np + 4'd2;
        end
        if (opc == OP_RETI || opc == 8'h45 || opc == 8'h55 ||
            opc == 8'h65 || opc == 8'h75) begin
          res.flow_class = FLOW_RET;
        end
      end else begin
        res.prefix_group = pfx;
        res.opcode_byte  = b;
        if (sz == 2'd2) begin
          res.immediate      = {8'h00, bx[at]};
          res.immediate_size = IMM_8;
        end else if (sz == 2'd3) begin
          res.immediate      = {bx[at + 4'd1], bx[at]};
          res.immediate_size = IMM_16;
        end
        if (dd) begin
          res.displacement      = bx[np + 4'd1];
          res.uses_displacement = 1'b1;
        end
        res.is_halt = (b == OP_HALT) && (pfx == GRP_NONE);
        len = np + {3'd0, dd} + {2'd0, sz};
        e = {{8{res.immediate[7]}}, res.immediate[7:0]};
        if (b == OP_JR || b == OP_DJNZ || (b & MASK_E7) == 8'h20) begin
          res.flow_class    = (b == OP_JR) ? FLOW_JP : FLOW_JPCC;
          res.target_valid  = 1'b1;
          res.branch_target = addr + {12'd0, len} + e;
        end else if (b == OP_JP) begin
          res.flow_class    = FLOW_JP;
          res.target_valid  = 1'b1;
          res.branch_target = res.immediate;
        end else if ((b & MASK_C7) == 8'hC2) begin
          res.flow_class    = FLOW_JPCC;
          res.target_valid  = 1'b1;
          res.branch_target = res.immediate;
        end else if (b == OP_CALL) begin
          res.flow_class    = FLOW_CALL;
          res.target_valid  = 1'b1;
          res.branch_target = res.immediate;
        end else if ((b & MASK_C7) == 8'hC4) begin
          res.flow_class    = FLOW_CALLC;
          res.target_valid  = 1'b1;
          res.branch_target = res.immediate;
        end else if ((b & MASK_C7) == MASK_C7) begin
          res.flow_class    = FLOW_CALL;
          res.target_valid  = 1'b1;
          res.branch_target = {8'h00, b & MASK_RST};
        end else if (b == OP_RET) begin
          res.flow_class = FLOW_RET;
        end else if ((b & MASK_C7) == 8'hC0) begin
          res.flow_class = FLOW_RETCC;
        end else if (b == OP_JP_HL) begin
          res.flow_class = FLOW_JP;
        end
      end
      if (len == 4'd0) len = 4'd1;
    end
    res.insn_length = (len > 4'd4) ? 3'd4 : len[2:0];
  end

endmodule
`default_nettype wire
